// File: hw/rtl/scpc_pkg.sv
// scpc_pkg: shared types, constants and the crc-32 byte update for the
// sequenced crc-32 packet checker; no dependencies
package scpc_pkg;

	localparam int unsigned SIZE_W  = 25;
	localparam int unsigned SEQ_W   = 32;
	localparam int unsigned LEN_W   = 16;
	localparam int unsigned POS_W   = 17;
	localparam int unsigned CRC_W   = 32;
	localparam int unsigned CFG_W   = 32;

	localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;
	localparam logic [POS_W-1:0] HDR_BYTES  = 17'd8;
	localparam logic [POS_W-1:0] TAIL_BYTES = 17'd4;
	localparam logic [POS_W-1:0] POS_MAX    = 17'h1FFFF;
	localparam logic [31:0] MAX_TRANSFER_BYTES_DEF = 32'd16777216;

	typedef enum logic [1:0] {
		CMD_BYTE   = 2'd0,
		CMD_START  = 2'd1,
		CMD_CANCEL = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_OUT_OF_ORDER = 2'd1,
		ST_CRC_ERROR    = 2'd2,
		ST_NO_SPACE     = 2'd3
	} status_t;

	typedef enum logic {
		REG_TRANSFER_SIZE = 1'b0,
		REG_TOTAL_CHUNKS  = 1'b1
	} reg_idx_t;

	// reflected crc-32, one byte, bit at a time
	function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
		input logic [7:0] b);
		logic [CRC_W-1:0] c;
		c = crc_in ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = (c >> 1) ^ (CRC_POLY & {CRC_W{c[0]}});
		end
		return c;
	endfunction

endpackage

// File: hw/rtl/sequenced_crc32_packet_checker.sv
// sequenced_crc32_packet_checker: top level, packet parse, crc-32 check and
// transfer accounting; depends on scpc_pkg
//
// path: a packet's last byte passes through the input register, then the result register
// throughput: one beat per cycle while no last byte waits on a stalled result; crc update is combinational
// reset: inactive, counters cleared, crc at all ones, no result pending
module sequenced_crc32_packet_checker
	import scpc_pkg::*;
#(
	parameter logic [31:0] MAX_TRANSFER_BYTES = MAX_TRANSFER_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic              cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              item_valid,
	output logic              item_stall,
	input  logic [1:0]        cmd,
	input  logic [7:0]        data_byte,
	input  logic              last_byte,
	output logic              res_valid,
	input  logic              res_stall,
	output logic [1:0]        status,
	output logic [SEQ_W-1:0]  sequence_res,
	output logic              sequence_valid,
	output logic [SIZE_W-1:0] received_total,
	output logic              transfer_complete
);

	logic [SIZE_W-1:0] transfer_size_q;
	logic [SEQ_W-1:0]  total_chunks_q;

	logic              valid_s1;
	logic [1:0]        cmd_s1;
	logic [7:0]        data_s1;
	logic              last_s1;

	logic              active_q;
	logic [SEQ_W-1:0]  exp_seq_q;
	logic [SIZE_W-1:0] rx_bytes_q;
	logic [POS_W-1:0]  pos_q;
	logic              ver_good_q;
	logic [SEQ_W-1:0]  hdr_seq_q;
	logic [LEN_W-1:0]  hdr_len_q;
	logic [CRC_W-1:0]  trail_q;
	logic [CRC_W-1:0]  crc_q;

	logic              res_valid_q;
	status_t           status_q;
	logic [SEQ_W-1:0]  seq_res_q;
	logic              seq_valid_q;
	logic [SIZE_W-1:0] rx_total_q;
	logic              complete_q;

	logic              emit;
	logic              adv;
	logic              is_ctl;
	logic              is_byte;

	logic              ver_good_n;
	logic [SEQ_W-1:0]  hdr_seq_n;
	logic [LEN_W-1:0]  hdr_len_n;
	logic [CRC_W-1:0]  trail_n;
	logic [CRC_W-1:0]  crc_n;
	logic [POS_W-1:0]  pos_n;
	logic [POS_W:0]    len_need;
	logic [SIZE_W:0]   sum_n;
	logic              hdr_bad;
	status_t           status_n;
	logic              seq_valid_n;
	logic              ok_n;
	logic [SEQ_W-1:0]  exp_seq_n;
	logic [SIZE_W-1:0] rx_bytes_n;
	logic              start_ok;

	assign is_byte = (cmd_t'(cmd_s1) == CMD_BYTE);
	assign is_ctl  = (cmd_t'(cmd_s1) == CMD_START) || (cmd_t'(cmd_s1) == CMD_CANCEL);
	assign emit    = valid_s1 && is_byte && last_s1;
	assign adv     = valid_s1 && (!emit || !res_valid_q || !res_stall);
	assign item_stall = valid_s1 && !adv;

	assign start_ok = (transfer_size_q != '0)
		&& ({{(32-SIZE_W){1'b0}}, transfer_size_q} <= MAX_TRANSFER_BYTES)
		&& (total_chunks_q != '0);

	always_comb begin
		ver_good_n = ver_good_q;
		hdr_seq_n  = hdr_seq_q;
		hdr_len_n  = hdr_len_q;
		case (pos_q)
			17'd0: ver_good_n = (data_s1 == 8'd1);
			17'd2: hdr_seq_n[7:0]   = data_s1;
			17'd3: hdr_seq_n[15:8]  = data_s1;
			17'd4: hdr_seq_n[23:16] = data_s1;
			17'd5: hdr_seq_n[31:24] = data_s1;
			17'd6: hdr_len_n[7:0]   = data_s1;
			17'd7: hdr_len_n[15:8]  = data_s1;
			default: ;
		endcase

		crc_n = (pos_q >= HDR_BYTES + TAIL_BYTES) ? crc_byte(crc_q, trail_q[7:0]) : crc_q;
		trail_n = (pos_q >= HDR_BYTES) ? {data_s1, trail_q[CRC_W-1:8]} : trail_q;
		pos_n = (pos_q != POS_MAX) ? pos_q + 1'b1 : pos_q;

		// packet length must be header + payload + crc
		len_need = {1'b0, HDR_BYTES + TAIL_BYTES - 1'b1} + {{(POS_W+1-LEN_W){1'b0}}, hdr_len_n};
		sum_n = {1'b0, rx_bytes_q} + {{(SIZE_W+1-LEN_W){1'b0}}, hdr_len_n};

		hdr_bad = !active_q || (pos_q < HDR_BYTES + TAIL_BYTES - 1'b1) || !ver_good_n;
		seq_valid_n = !hdr_bad;
		ok_n = 1'b0;
		if (hdr_bad) begin
			status_n = ST_OUT_OF_ORDER;
		end else if ((hdr_seq_n != exp_seq_q) || ({1'b0, pos_q} != len_need)) begin
			status_n = ST_OUT_OF_ORDER;
		end else if (~crc_n != trail_n) begin
			status_n = ST_CRC_ERROR;
		end else if (sum_n > {1'b0, transfer_size_q}) begin
			status_n = ST_NO_SPACE;
		end else begin
			status_n = ST_OK;
			ok_n = 1'b1;
		end
		exp_seq_n  = ok_n ? exp_seq_q + 1'b1 : exp_seq_q;
		rx_bytes_n = ok_n ? sum_n[SIZE_W-1:0] : rx_bytes_q;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			transfer_size_q <= '0;
			total_chunks_q  <= '0;
		end else if (cfg_write) begin
			unique case (reg_idx_t'(cfg_index))
				REG_TRANSFER_SIZE: transfer_size_q <= cfg_data[SIZE_W-1:0];
				REG_TOTAL_CHUNKS:  total_chunks_q  <= cfg_data[SEQ_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			cmd_s1  <= cmd;
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// packet and transfer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= 1'b0;
			exp_seq_q  <= '0;
			rx_bytes_q <= '0;
			pos_q      <= '0;
			ver_good_q <= 1'b0;
			hdr_seq_q  <= '0;
			hdr_len_q  <= '0;
			trail_q    <= '0;
			crc_q      <= CRC_INIT;
		end else if (adv) begin
			if (is_ctl) begin
				active_q   <= (cmd_t'(cmd_s1) == CMD_START) && start_ok;
				exp_seq_q  <= '0;
				rx_bytes_q <= '0;
				pos_q      <= '0;
				ver_good_q <= 1'b0;
				hdr_seq_q  <= '0;
				hdr_len_q  <= '0;
				trail_q    <= '0;
				crc_q      <= CRC_INIT;
			end else if (is_byte) begin
				if (last_s1) begin
					exp_seq_q  <= exp_seq_n;
					rx_bytes_q <= rx_bytes_n;
					pos_q      <= '0;
					ver_good_q <= 1'b0;
					hdr_seq_q  <= '0;
					hdr_len_q  <= '0;
					trail_q    <= '0;
					crc_q      <= CRC_INIT;
				end else begin
					pos_q      <= pos_n;
					ver_good_q <= ver_good_n;
					hdr_seq_q  <= hdr_seq_n;
					hdr_len_q  <= hdr_len_n;
					trail_q    <= trail_n;
					crc_q      <= crc_n;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= (res_valid_q && res_stall) || (adv && emit);
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			status_q    <= status_n;
			seq_res_q   <= seq_valid_n ? hdr_seq_n : '0;
			seq_valid_q <= seq_valid_n;
			rx_total_q  <= rx_bytes_n;
			complete_q  <= (rx_bytes_n == transfer_size_q) && (exp_seq_n == total_chunks_q);
		end
	end

	assign res_valid         = res_valid_q;
	assign status            = status_q;
	assign sequence_res      = seq_res_q;
	assign sequence_valid    = seq_valid_q;
	assign received_total    = rx_total_q;
	assign transfer_complete = complete_q;

endmodule

// File: dv/sequenced_crc32_packet_checker_test.sv
// sequenced_crc32_packet_checker_test: self-checking bench for the packet checker,
// predicting every status beat from its own parse and crc of the byte stream;
// depends on scpc_pkg and the sequenced_crc32_packet_checker top level
`timescale 1ns / 1ps

module sequenced_crc32_packet_checker_test;
	import scpc_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [31:0] SIZE_CAP = MAX_TRANSFER_BYTES_DEF;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] b;
		logic       last;
	} beat_t;

	typedef struct {
		status_t     code;
		logic [31:0] seq;
		logic        seq_ok;
		logic [24:0] total;
		logic        done;
	} verdict_t;

	typedef enum {PK_GOOD, PK_BAD_VER, PK_BAD_CRC, PK_LONG, PK_SHORT} pkt_kind_t;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              cfg_write = 1'b0;
	logic              cfg_index = 1'b0;
	logic [31:0]       cfg_data = '0;
	logic              item_valid = 1'b0;
	logic              item_stall;
	logic [1:0]        cmd = CMD_BYTE;
	logic [7:0]        data_byte = '0;
	logic              last_byte = 1'b0;
	logic              res_valid;
	logic              res_stall = 1'b0;
	logic [1:0]        status;
	logic [31:0]       sequence_res;
	logic              sequence_valid;
	logic [24:0]       received_total;
	logic              transfer_complete;

	sequenced_crc32_packet_checker uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.item_valid(item_valid), .item_stall(item_stall),
		.cmd(cmd), .data_byte(data_byte), .last_byte(last_byte),
		.res_valid(res_valid), .res_stall(res_stall),
		.status(status), .sequence_res(sequence_res), .sequence_valid(sequence_valid),
		.received_total(received_total), .transfer_complete(transfer_complete)
	);

	beat_t    outbox[$];
	verdict_t verdicts[$];
	beat_t    cur;
	int       faults = 0;
	int       beats_posted = 0;
	int       reports_seen = 0;
	int       tx_gap = 0;
	int       rx_gap = 0;
	int       hold_left = 0;
	bit       hold_done = 0;
	bit       calm = 0;

	// configuration as the checker sees it
	logic [24:0] cfg_size = '0;
	logic [31:0] cfg_chunks = '0;

	// predicted checker state
	logic        m_active = 1'b0;
	logic [31:0] m_next_seq = '0;
	logic [24:0] m_total = '0;
	logic [16:0] m_pos = '0;
	logic        m_ver_ok = 1'b0;
	logic [31:0] m_hdr_seq = '0;
	logic [15:0] m_hdr_len = '0;
	logic [31:0] m_tail = '0;
	logic [31:0] m_crc = CRC_INIT;

	// stimulus-side view of the transfer, used only to shape packets
	logic        g_active = 1'b0;
	logic [31:0] g_seq = '0;
	logic [24:0] g_total = '0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#100_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic logic [31:0] crc32_step(input logic [31:0] c, input logic [7:0] d);
		logic [31:0] r;
		r = c;
		for (int i = 0; i < 8; i++) begin
			if (r[0] ^ d[i]) begin
				r = (r >> 1) ^ CRC_POLY;
			end else begin
				r = r >> 1;
			end
		end
		return r;
	endfunction

	task automatic flag_mismatch(input string msg);
		faults++;
		$display("mismatch at %0t: %s", $time, msg);
	endtask

	task automatic clear_packet();
		m_pos = '0;
		m_ver_ok = 1'b0;
		m_hdr_seq = '0;
		m_hdr_len = '0;
		m_tail = '0;
		m_crc = CRC_INIT;
	endtask

	task automatic judge_beat(input beat_t bt);
		verdict_t    v;
		logic [16:0] p;
		logic [17:0] len;
		logic [25:0] sum;
		if (bt.cmd == CMD_START || bt.cmd == CMD_CANCEL) begin
			clear_packet();
			m_next_seq = '0;
			m_total = '0;
			m_active = bt.cmd == CMD_START && cfg_size != 0 &&
				{7'd0, cfg_size} <= SIZE_CAP && cfg_chunks != 0;
		end else if (bt.cmd == CMD_BYTE) begin
			p = m_pos;
			if (p == 0) begin
				m_ver_ok = bt.b == 8'd1;
			end else if (p >= 2 && p <= 5) begin
				m_hdr_seq[8*(p-2) +: 8] = bt.b;
			end else if (p == 6 || p == 7) begin
				m_hdr_len[8*(p-6) +: 8] = bt.b;
			end
			if (p >= HDR_BYTES + TAIL_BYTES) begin
				m_crc = crc32_step(m_crc, m_tail[7:0]);
			end
			if (p >= HDR_BYTES) begin
				m_tail = {bt.b, m_tail[31:8]};
			end
			if (m_pos != POS_MAX) begin
				m_pos = m_pos + 17'd1;
			end
			if (bt.last) begin
				len = {1'b0, p} + 18'd1;
				v.seq = '0;
				v.seq_ok = 1'b0;
				sum = {1'b0, m_total} + {10'd0, m_hdr_len};
				if (!m_active || len < 18'd12 || !m_ver_ok) begin
					v.code = ST_OUT_OF_ORDER;
				end else begin
					v.seq_ok = 1'b1;
					v.seq = m_hdr_seq;
					if (m_hdr_seq != m_next_seq || len != {2'd0, m_hdr_len} + 18'd12) begin
						v.code = ST_OUT_OF_ORDER;
					end else if ((m_crc ^ CRC_INIT) != m_tail) begin
						v.code = ST_CRC_ERROR;
					end else if (sum > {1'b0, cfg_size}) begin
						v.code = ST_NO_SPACE;
					end else begin
						v.code = ST_OK;
						m_total = sum[24:0];
						m_next_seq = m_next_seq + 32'd1;
					end
				end
				clear_packet();
				v.total = m_total;
				v.done = m_total == cfg_size && m_next_seq == cfg_chunks;
				verdicts.push_back(v);
			end
		end
	endtask

	// sender
	always @(posedge clk) begin
		if (item_valid && !item_stall) begin
			judge_beat(cur);
		end
		if (!(item_valid && item_stall)) begin
			if (tx_gap != 0) begin
				tx_gap--;
				item_valid <= 1'b0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				tx_gap = $urandom_range(0, 4);
				item_valid <= 1'b0;
			end else if (outbox.size() != 0) begin
				cur = outbox.pop_front();
				item_valid <= 1'b1;
				cmd <= cur.cmd;
				data_byte <= cur.b;
				last_byte <= cur.last;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// receiver
	always @(posedge clk) begin
		verdict_t v;
		if (res_valid && !res_stall) begin
			reports_seen++;
			if (verdicts.size() == 0) begin
				flag_mismatch("status beat with nothing pending");
			end else begin
				v = verdicts.pop_front();
				if (status !== v.code)
					flag_mismatch($sformatf("status %0d, want %0d", status, v.code));
				if (sequence_res !== v.seq)
					flag_mismatch($sformatf("sequence %h, want %h", sequence_res, v.seq));
				if (sequence_valid !== v.seq_ok)
					flag_mismatch($sformatf("sequence_valid %b, want %b",
						sequence_valid, v.seq_ok));
				if (received_total !== v.total)
					flag_mismatch($sformatf("received_total %0d, want %0d",
						received_total, v.total));
				if (transfer_complete !== v.done)
					flag_mismatch($sformatf("transfer_complete %b, want %b",
						transfer_complete, v.done));
			end
		end
		if (hold_left != 0) begin
			hold_left--;
			res_stall <= 1'b1;
		end else if (!hold_done && reports_seen >= 30 && outbox.size() > 60) begin
			hold_done = 1;
			hold_left = 300;
			res_stall <= 1'b1;
		end else if (calm) begin
			res_stall <= 1'b0;
		end else if (rx_gap != 0) begin
			rx_gap--;
			res_stall <= 1'b1;
		end else if ($urandom_range(0, 7) == 0) begin
			rx_gap = $urandom_range(0, 4);
			res_stall <= 1'b1;
		end else begin
			res_stall <= 1'b0;
		end
	end

	task automatic post(input logic [1:0] c, input logic [7:0] b, input logic l);
		outbox.push_back('{c, b, l});
		beats_posted++;
		if (c == CMD_START || c == CMD_CANCEL) begin
			g_active = c == CMD_START && cfg_size != 0 &&
				{7'd0, cfg_size} <= SIZE_CAP && cfg_chunks != 0;
			g_seq = '0;
			g_total = '0;
		end
	endtask

	task automatic queue_packet(input pkt_kind_t kind, input logic [31:0] seq, input int ln);
		logic [7:0]  pk[$];
		logic [31:0] crc;
		int          n;
		crc = CRC_INIT;
		pk.push_back(kind == PK_BAD_VER ? 8'($urandom_range(2, 256)) : 8'd1);
		pk.push_back(8'($urandom));
		for (int i = 0; i < 4; i++) pk.push_back(seq[8*i +: 8]);
		pk.push_back(ln[7:0]);
		pk.push_back(ln[15:8]);
		n = (kind == PK_LONG) ? ln + 1 : ln;
		for (int i = 0; i < n; i++) begin
			pk.push_back(8'($urandom));
			crc = crc32_step(crc, pk[pk.size()-1]);
		end
		crc = crc ^ CRC_INIT;
		if (kind == PK_BAD_CRC) crc = crc ^ (32'd1 << $urandom_range(0, 31));
		for (int i = 0; i < 4; i++) pk.push_back(crc[8*i +: 8]);
		n = (kind == PK_SHORT) ? $urandom_range(1, 11) : pk.size();
		for (int i = 0; i < n; i++) post(CMD_BYTE, pk[i], i == n - 1);
		if (kind == PK_GOOD && g_active && seq == g_seq && g_total + ln <= cfg_size) begin
			g_total = g_total + 25'(ln);
			g_seq = g_seq + 32'd1;
		end
	endtask

	task automatic set_reg(input reg_idx_t idx, input logic [31:0] val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		if (idx == REG_TRANSFER_SIZE) begin
			cfg_size = val[24:0];
		end else begin
			cfg_chunks = val;
		end
		@(negedge clk);
	endtask

	// sender idle and every status beat in, then room for a beat still in flight
	task automatic drain();
		do @(negedge clk);
		while (outbox.size() != 0 || item_valid || verdicts.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		logic [24:0] sz;
		logic [31:0] ch;
		int          r;
		int          n;
		int          left;
		int          mark;
		int          ln;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		set_reg(REG_TRANSFER_SIZE, 32'd0);
		set_reg(REG_TOTAL_CHUNKS, 32'd0);
		post(CMD_BYTE, 8'hFF, 1'b1);
		post(CMD_START, 8'h00, 1'b0);
		post(CMD_UNUSED, 8'hFF, 1'b1);
		drain();

		set_reg(REG_TRANSFER_SIZE, 32'd3);
		set_reg(REG_TOTAL_CHUNKS, 32'd2);
		post(CMD_START, 8'h00, 1'b0);
		queue_packet(PK_SHORT, 32'd0, 0);
		queue_packet(PK_BAD_VER, 32'd0, 0);
		queue_packet(PK_GOOD, 32'd7, 0);
		queue_packet(PK_LONG, 32'd0, 0);
		queue_packet(PK_BAD_CRC, 32'd0, 1);
		queue_packet(PK_GOOD, 32'd0, 1);
		queue_packet(PK_GOOD, 32'd1, 3);
		queue_packet(PK_GOOD, 32'd1, 2);
		queue_packet(PK_GOOD, 32'd2, 0);
		post(CMD_CANCEL, 8'hFF, 1'b1);
		queue_packet(PK_GOOD, 32'd0, 0);
		drain();

		// overlong packet: the byte position saturates and the length check fails
		set_reg(REG_TRANSFER_SIZE, SIZE_CAP);
		set_reg(REG_TOTAL_CHUNKS, 32'hFFFF_FFFF);
		post(CMD_START, 8'h00, 1'b0);
		post(CMD_BYTE, 8'd1, 1'b0);
		post(CMD_BYTE, 8'($urandom), 1'b0);
		for (int i = 0; i < 4; i++) post(CMD_BYTE, 8'd0, 1'b0);
		post(CMD_BYTE, 8'hFF, 1'b0);
		post(CMD_BYTE, 8'hFF, 1'b0);
		for (int i = 8; i < int'(POS_MAX) + 4; i++)
			post(CMD_BYTE, 8'($urandom), i == int'(POS_MAX) + 3);
		queue_packet(PK_GOOD, 32'd0, 5);

		for (int ph = 0; ph < 9; ph++) begin
			drain();
			case (ph)
				0: begin sz = SIZE_CAP[24:0]; ch = 32'hFFFF_FFFF; end
				1: begin sz = 25'd1; ch = 32'd1; end
				2: begin sz = 25'd150; ch = 32'd6; end
				3: begin sz = SIZE_CAP[24:0] + 25'd1; ch = 32'd3; end
				4: begin sz = 25'h1FF_FFFF; ch = 32'd4; end
				5: begin sz = 25'd0; ch = 32'd5; end
				6: begin sz = 25'd100; ch = 32'd0; end
				default: begin
					sz = 25'($urandom_range(20, 300));
					ch = $urandom_range(2, 10);
				end
			endcase
			if (ph >= 7) calm = 1;
			set_reg(REG_TRANSFER_SIZE, {7'($urandom), sz});
			set_reg(REG_TOTAL_CHUNKS, ch);
			post(CMD_START, 8'($urandom), 1'($urandom));
			mark = beats_posted;
			while (beats_posted - mark < 190) begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					left = int'(cfg_size) - int'(g_total);
					if (g_active && g_seq + 32'd1 == cfg_chunks && left >= 0 && left <= 40)
						ln = left;
					else
						ln = $urandom_range(0, 20);
					queue_packet(PK_GOOD, $urandom_range(0, 9) == 0 ? $urandom : g_seq, ln);
				end else if (r < 80) begin
					queue_packet(pkt_kind_t'($urandom_range(1, 4)), g_seq,
						$urandom_range(0, 20));
				end else if (r < 88) begin
					n = $urandom_range(1, 15);
					for (int i = 0; i < n; i++)
						post(CMD_BYTE, 8'($urandom),
							i == n - 1 || $urandom_range(0, 7) == 0);
				end else if (r < 93) begin
					post(CMD_UNUSED, 8'($urandom), 1'($urandom));
				end else if (r < 97) begin
					post(CMD_START, 8'($urandom), 1'($urandom));
				end else begin
					post(CMD_CANCEL, 8'($urandom), 1'($urandom));
					if ($urandom_range(0, 1) == 0)
						post(CMD_START, 8'($urandom), 1'($urandom));
				end
			end
		end
		drain();

		if (faults == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
